@@ rtl/tfg_pkg.sv @@
// Shared constants, codes and types of the tile fog grid engine.
package tfg_pkg;

    localparam int GRID_SIZE_DEF = 64;
    localparam int CELLS_DEF     = GRID_SIZE_DEF * GRID_SIZE_DEF;
    localparam int ADDR_W_DEF    = $clog2(CELLS_DEF);

    localparam logic [14:0] RATIO_MIN   = 15'd333;
    localparam logic [14:0] RATIO_MAX   = 15'd25600;
    localparam logic [7:0]  FOG_RESET   = 8'd255;
    localparam logic [14:0] RATIO_RESET = 15'd512;

    localparam logic [1:0] OP_STAMP  = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_SOFTEN = 2'd3;

    localparam logic CFG_FOG_ALPHA  = 1'b0;
    localparam logic CFG_FADE_RATIO = 1'b1;

    typedef struct packed {
        logic        start;
        logic [7:0]  num;
        logic [14:0] den;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] quot;
    } t_div_rsp;

endpackage

@@ rtl/tfg_in_if.sv @@
// Command word channel of the tile fog grid engine.
interface tfg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [5:0] col_a;
    logic [5:0] row_a;
    logic [5:0] col_b;
    logic [5:0] row_b;
    logic [5:0] radius;
    logic       visible;

    modport source(output valid, op, col_a, row_a, col_b, row_b, radius, visible,
                   input ready);
    modport sink(input valid, op, col_a, row_a, col_b, row_b, radius, visible,
                 output ready);
endinterface

@@ rtl/tfg_out_if.sv @@
// Result word channel of the tile fog grid engine.
interface tfg_out_if;
    logic       valid;
    logic       ready;
    logic       tile_visible;
    logic [1:0] done_op;

    modport source(output valid, tile_visible, done_op, input ready);
    modport sink(input valid, tile_visible, done_op, output ready);
endinterface

@@ rtl/tfg_mem.sv @@
// Alpha grid storage: one write port and one read port with registered read data.
module tfg_mem #(
    parameter int DEPTH  = tfg_pkg::CELLS_DEF,
    parameter int ADDR_W = tfg_pkg::ADDR_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tfg_div.sv @@
// Restoring divider, one quotient bit per cycle, for (num * 256) / den with num < den.
module tfg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tfg_pkg::t_div_req i_req,
    output tfg_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [14:0] r_rem;
    logic [7:0]  r_q;
    logic [14:0] r_den;
    logic [15:0] trial;
    logic        fits;

    // The partial remainder stays below the divisor, so 15 bits carry it.
    assign trial = {r_rem, 1'b0};
    assign fits  = trial >= 16'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= 15'(i_req.num);
            r_den <= i_req.den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? 15'(trial - 16'(r_den)) : trial[14:0];
            r_q   <= {r_q[6:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

@@ rtl/tile_fog_grid_engine.sv @@
// Top level of the tile fog grid engine: command sequencer around the alpha grid memory.
// After reset the block writes the fog reset alpha into every tile, one tile a cycle,
// and takes no command until that pass is over. Commands then run one at a time
// through the single write and read port of the grid memory: a fill writes every
// tile, a disc stamp walks the inner tiles, a query reads one tile, and a soften
// walks the rectangle twice, spending per tile one memory read of the tile and of
// each neighbor inside the grid, a run of the serial divider for each neighbor
// whose alpha times 256 exceeds the tile alpha times the ratio, and a write back.
// The done state then hands the result word to the output register once that
// register is free, and the register holds it while the next command is already taken.
module tile_fog_grid_engine #(
    parameter int GRID_SIZE = tfg_pkg::GRID_SIZE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tfg_in_if.sink       i_in,
    tfg_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [14:0]  i_cfg_data
);

    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIZE);
    localparam int XW    = 9;
    localparam int DW    = ((CW > 6) ? CW : 6) + 1;
    localparam int SW    = 2 * DW + 1;
    localparam logic [CW-1:0] TOP    = CW'(GRID_SIZE - 1);
    localparam logic [CW-1:0] INNER  = CW'(GRID_SIZE - 2);
    localparam logic [AW-1:0] LAST   = AW'(CELLS - 1);

    localparam logic [2:0] NB_CTR   = 3'd0;
    localparam logic [2:0] NB_RIGHT = 3'd1;
    localparam logic [2:0] NB_LEFT  = 3'd2;
    localparam logic [2:0] NB_DOWN  = 3'd3;
    localparam logic [2:0] NB_UP    = 3'd4;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_STAMP = 11'b00000000100,
        S_FILL  = 11'b00000001000,
        S_QRD   = 11'b00000010000,
        S_QCHK  = 11'b00000100000,
        S_SRD   = 11'b00001000000,
        S_SEV   = 11'b00010000000,
        S_SDIV  = 11'b00100000000,
        S_SWR   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]    r_fog;
    logic [14:0]   r_ratio;
    logic [14:0]   r_rc, n_rc;
    logic [1:0]    r_op, n_op;
    logic [7:0]    r_wval, n_wval;
    logic [5:0]    r_ca, n_ca;
    logic [5:0]    r_ra, n_ra;
    logic [11:0]   r_rad2, n_rad2;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_c1, n_c1, r_c2, n_c2, r_r1, n_r1, r_r2, n_r2;
    logic          r_pass, n_pass;
    logic [2:0]    r_k, n_k;
    logic [7:0]    r_m, n_m;
    logic [AW-1:0] r_lin, n_lin;
    logic          r_ans, n_ans;
    logic          r_ovalid, n_ovalid;
    logic          r_ovis, n_ovis;
    logic [1:0]    r_oop, n_oop;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    tfg_pkg::t_div_req div_req;
    tfg_pkg::t_div_rsp div_rsp;

    function automatic logic [AW-1:0] tile_addr(input logic [CW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(GRID_SIZE) + AW'(col);
    endfunction

    function automatic logic [XW-1:0] clamp9(input logic [XW-1:0] v,
                                             input logic [XW-1:0] lo,
                                             input logic [XW-1:0] hi);
        logic [XW-1:0] res;
        if (v < lo) res = lo;
        else if (v > hi) res = hi;
        else res = v;
        return res;
    endfunction

    tfg_mem #(.DEPTH(CELLS), .ADDR_W(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    tfg_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // Disc test for the stamp walk.
    logic signed [DW-1:0]   dx, dy;
    logic signed [2*DW-1:0] sqx, sqy;
    logic [SW-1:0]          dist2;
    logic                   in_disc;

    assign dx      = $signed(DW'(r_col)) - $signed(DW'(r_ca));
    assign dy      = $signed(DW'(r_row)) - $signed(DW'(r_ra));
    assign sqx     = dx * dx;
    assign sqy     = dy * dy;
    assign dist2   = SW'($unsigned(sqx)) + SW'($unsigned(sqy));
    assign in_disc = dist2 < SW'(r_rad2);

    // Softening compare: neighbor * 256 against m * ratio.
    logic [22:0] m_times_r;
    logic        lowers;

    assign m_times_r = 23'(r_m) * 23'(r_rc);
    assign lowers    = 23'({mem_rdata, 8'd0}) > m_times_r;

    // Neighbor selection for the soften read.
    logic [CW-1:0] nb_row, nb_col;
    logic          nb_ok;

    always_comb begin
        nb_row = r_row;
        nb_col = r_col;
        nb_ok  = 1'b1;
        unique case (r_k)
            NB_RIGHT: begin
                nb_col = r_col + CW'(1);
                nb_ok  = r_col != TOP;
            end
            NB_LEFT:  nb_col = r_col - CW'(1);
            NB_DOWN: begin
                nb_row = r_row + CW'(1);
                nb_ok  = r_row != TOP;
            end
            NB_UP:    nb_row = r_row - CW'(1);
            default: ;
        endcase
    end

    // Rectangle clamp of the incoming soften command.
    logic [XW-1:0] c1w, c2w, r1w, r2w;

    always_comb begin
        c1w = clamp9(XW'(i_in.col_a), XW'(1), XW'(TOP));
        c2w = clamp9(XW'(i_in.col_b), c1w, XW'(TOP));
        r1w = clamp9(XW'(i_in.row_a), XW'(1), XW'(TOP));
        r2w = clamp9(XW'(i_in.row_b), r1w, XW'(TOP));
    end

    logic accept;
    assign i_in.ready = r_state == S_IDLE;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_state  = r_state;
        n_rc     = r_rc;
        n_op     = r_op;
        n_wval   = r_wval;
        n_ca     = r_ca;
        n_ra     = r_ra;
        n_rad2   = r_rad2;
        n_row    = r_row;
        n_col    = r_col;
        n_c1     = r_c1;
        n_c2     = r_c2;
        n_r1     = r_r1;
        n_r2     = r_r2;
        n_pass   = r_pass;
        n_k      = r_k;
        n_m      = r_m;
        n_lin    = r_lin;
        n_ans    = r_ans;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ovis   = r_ovis;
        n_oop    = r_oop;
        mem_we    = 1'b0;
        mem_waddr = tile_addr(r_row, r_col);
        mem_wdata = r_wval;
        mem_raddr = tile_addr(nb_row, nb_col);
        div_req.start = 1'b0;
        div_req.num   = mem_rdata;
        div_req.den   = r_rc;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_lin;
                mem_wdata = tfg_pkg::FOG_RESET;
                n_lin     = r_lin + AW'(1);
                if (r_lin == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op   = i_in.op;
                    n_wval = i_in.visible ? 8'd0 : r_fog;
                    n_ca   = i_in.col_a;
                    n_ra   = i_in.row_a;
                    n_rad2 = 12'(i_in.radius) * 12'(i_in.radius);
                    n_ans  = 1'b0;
                    n_lin  = '0;
                    n_k    = NB_CTR;
                    n_pass = 1'b0;
                    if (r_ratio < tfg_pkg::RATIO_MIN) n_rc = tfg_pkg::RATIO_MIN;
                    else if (r_ratio > tfg_pkg::RATIO_MAX) n_rc = tfg_pkg::RATIO_MAX;
                    else n_rc = r_ratio;
                    n_c1 = CW'(c1w);
                    n_c2 = CW'(c2w);
                    n_r1 = CW'(r1w);
                    n_r2 = CW'(r2w);
                    unique case (i_in.op)
                        tfg_pkg::OP_STAMP: begin
                            n_row   = CW'(1);
                            n_col   = CW'(1);
                            n_state = S_STAMP;
                        end
                        tfg_pkg::OP_FILL: n_state = S_FILL;
                        tfg_pkg::OP_QUERY: begin
                            n_row = CW'(i_in.row_a);
                            n_col = CW'(i_in.col_a);
                            if (XW'(i_in.col_a) < XW'(GRID_SIZE) &&
                                XW'(i_in.row_a) < XW'(GRID_SIZE)) begin
                                n_state = S_QRD;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        tfg_pkg::OP_SOFTEN: begin
                            n_row   = CW'(r1w);
                            n_col   = CW'(c1w);
                            n_state = S_SRD;
                        end
                        default: ;
                    endcase
                end
            end
            S_STAMP: begin
                mem_we = in_disc;
                if (r_col == INNER) begin
                    n_col = CW'(1);
                    n_row = r_row + CW'(1);
                    if (r_row == INNER) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_lin;
                n_lin     = r_lin + AW'(1);
                if (r_lin == LAST) begin
                    n_state = S_DONE;
                end
            end
            S_QRD: begin
                mem_raddr = tile_addr(r_row, r_col);
                n_state   = S_QCHK;
            end
            S_QCHK: begin
                n_ans   = mem_rdata < (r_fog >> 1);
                n_state = S_DONE;
            end
            S_SRD: begin
                if (nb_ok) begin
                    n_state = S_SEV;
                end else if (r_k == NB_UP) begin
                    n_state = S_SWR;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_SEV: begin
                if (r_k == NB_CTR) begin
                    n_m     = mem_rdata;
                    n_k     = NB_RIGHT;
                    n_state = S_SRD;
                end else if (lowers) begin
                    div_req.start = 1'b1;
                    n_state       = S_SDIV;
                end else if (r_k == NB_UP) begin
                    n_state = S_SWR;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_SRD;
                end
            end
            S_SDIV: begin
                if (div_rsp.done) begin
                    n_m = div_rsp.quot;
                    if (r_k == NB_UP) begin
                        n_state = S_SWR;
                    end else begin
                        n_k     = r_k + 3'd1;
                        n_state = S_SRD;
                    end
                end
            end
            S_SWR: begin
                mem_we    = 1'b1;
                mem_wdata = r_m;
                n_k       = NB_CTR;
                n_state   = S_SRD;
                if (!r_pass) begin
                    // The forward pass ends on the last corner, where the
                    // backward pass begins.
                    if (r_col == r_c2) begin
                        if (r_row == r_r2) begin
                            n_pass = 1'b1;
                        end else begin
                            n_col = r_c1;
                            n_row = r_row + CW'(1);
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end else begin
                    if (r_col == r_c1) begin
                        if (r_row == r_r1) begin
                            n_state = S_DONE;
                        end else begin
                            n_col = r_c2;
                            n_row = r_row - CW'(1);
                        end
                    end else begin
                        n_col = r_col - CW'(1);
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_ovis   = r_ans;
                    n_oop    = r_op;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_lin    <= '0;
            r_ovalid <= 1'b0;
            r_fog    <= tfg_pkg::FOG_RESET;
            r_ratio  <= tfg_pkg::RATIO_RESET;
        end else begin
            r_state  <= n_state;
            r_lin    <= n_lin;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tfg_pkg::CFG_FOG_ALPHA:  r_fog   <= i_cfg_data[7:0];
                    tfg_pkg::CFG_FADE_RATIO: r_ratio <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rc   <= n_rc;
        r_op   <= n_op;
        r_wval <= n_wval;
        r_ca   <= n_ca;
        r_ra   <= n_ra;
        r_rad2 <= n_rad2;
        r_row  <= n_row;
        r_col  <= n_col;
        r_c1   <= n_c1;
        r_c2   <= n_c2;
        r_r1   <= n_r1;
        r_r2   <= n_r2;
        r_pass <= n_pass;
        r_k    <= n_k;
        r_m    <= n_m;
        r_ans  <= n_ans;
        r_ovis <= n_ovis;
        r_oop  <= n_oop;
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.tile_visible = r_ovis;
    assign o_out.done_op      = r_oop;

`ifndef SYNTHESIS
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_FILL ||
                    r_state == S_STAMP || r_state == S_SWR))
        else $error("grid written outside a writing state");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_SDIV)
        else $error("divider finished while nobody waits for it");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("accepted command did not start");

    a_writeback_after_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWR |-> r_k == NB_UP)
        else $error("soften write-back before all neighbors were checked");
`endif

endmodule

@@ tb/sv/tile_fog_grid_engine_tb.sv @@
// Self-checking testbench of the tile fog grid engine: random and directed commands
// with a cycle-free grid predictor and an in-order result scoreboard.
module tile_fog_grid_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GS    = tfg_pkg::GRID_SIZE_DEF;
    localparam int CELLS = tfg_pkg::CELLS_DEF;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] col_a;
        logic [5:0] row_a;
        logic [5:0] col_b;
        logic [5:0] row_b;
        logic [5:0] radius;
        logic       visible;
    } t_cmd;

    typedef struct packed {
        logic       tile_visible;
        logic [1:0] done_op;
    } t_res;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [14:0] i_cfg_data;

    tfg_in_if  in_ch();
    tfg_out_if out_ch();

    tile_fog_grid_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Predictor state.
    logic [7:0]  grid_model [CELLS];
    logic [7:0]  fog_model;
    logic [14:0] ratio_model;

    t_cmd pending_cmds[$];
    t_res expected_res[$];
    int   errors;
    bit   hold_sender;
    int   gap_left;
    int   burst_left;
    int   stall_phase;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void enqueue_cmd(t_cmd cmd);
        pending_cmds.insert(pending_cmds.size(), cmd);
    endfunction

    function automatic void add_expected(t_res res);
        expected_res.insert(expected_res.size(), res);
    endfunction

    function automatic logic [7:0] soften_value(int c, int r, logic [31:0] ratio);
        logic [31:0] m;
        logic [31:0] n;
        m = 32'(grid_model[r * GS + c]);
        for (int k = 0; k < 4; k++) begin
            int nc;
            int nr;
            nc = c + (k == 0 ? 1 : (k == 1 ? -1 : 0));
            nr = r + (k == 2 ? 1 : (k == 3 ? -1 : 0));
            if (nc < GS && nr < GS) begin
                n = 32'(grid_model[nr * GS + nc]);
                if (n * 256 > m * ratio) m = (n * 256) / ratio;
            end
        end
        return m[7:0];
    endfunction

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_res predict_command(t_cmd cmd);
        t_res res;
        logic [7:0] wval;
        logic [31:0] ratio;
        int c1, c2, r1, r2;
        int dx, dy, rad;
        res.done_op = cmd.op;
        res.tile_visible = 1'b0;
        wval = cmd.visible ? 8'd0 : fog_model;
        case (cmd.op)
            tfg_pkg::OP_STAMP: begin
                rad = int'(cmd.radius);
                for (int r = 1; r < GS - 1; r++)
                    for (int c = 1; c < GS - 1; c++) begin
                        dx = c - int'(cmd.col_a);
                        dy = r - int'(cmd.row_a);
                        if (dx * dx + dy * dy < rad * rad)
                            grid_model[r * GS + c] = wval;
                    end
            end
            tfg_pkg::OP_FILL: begin
                for (int i = 0; i < CELLS; i++) grid_model[i] = wval;
            end
            tfg_pkg::OP_QUERY: begin
                res.tile_visible = grid_model[int'(cmd.row_a) * GS + int'(cmd.col_a)] <
                                   fog_model / 2;
            end
            default: begin
                ratio = clampi(int'(ratio_model), int'(tfg_pkg::RATIO_MIN),
                               int'(tfg_pkg::RATIO_MAX));
                c1 = clampi(int'(cmd.col_a), 1, GS - 1);
                c2 = clampi(int'(cmd.col_b), c1, GS - 1);
                r1 = clampi(int'(cmd.row_a), 1, GS - 1);
                r2 = clampi(int'(cmd.row_b), r1, GS - 1);
                for (int r = r1; r <= r2; r++)
                    for (int c = c1; c <= c2; c++)
                        grid_model[r * GS + c] = soften_value(c, r, ratio);
                for (int r = r2; r >= r1; r--)
                    for (int c = c2; c >= c1; c--)
                        grid_model[r * GS + c] = soften_value(c, r, ratio);
            end
        endcase
        return res;
    endfunction

    // Driver: bursts of words with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else begin
            t_cmd cmd;
            if (in_ch.valid && in_ch.ready) begin
                cmd = pending_cmds.pop_front();
                add_expected(predict_command(cmd));
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Hold the word until it is taken.
            end else if (hold_sender || pending_cmds.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else begin
                cmd = pending_cmds[0];
                in_ch.valid   <= 1'b1;
                in_ch.op      <= cmd.op;
                in_ch.col_a   <= cmd.col_a;
                in_ch.row_a   <= cmd.row_a;
                in_ch.col_b   <= cmd.col_b;
                in_ch.row_b   <= cmd.row_b;
                in_ch.radius  <= cmd.radius;
                in_ch.visible <= cmd.visible;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= int'($urandom_range(0, 4));
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 :
                                int'($urandom_range(1, 30));
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            t_res got;
            t_res exp_word;
            stall_phase <= stall_phase + 1;
            // Long stretches of full readiness alternate with periodic stalls.
            out_ch.ready <= (stall_phase[9]) ? 1'b1 : (stall_phase % 7 < 4);
            if (out_ch.valid && out_ch.ready) begin
                got.tile_visible = out_ch.tile_visible;
                got.done_op = out_ch.done_op;
                if (expected_res.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word %b", $time, got);
                end else begin
                    exp_word = expected_res.pop_front();
                    if (got.done_op !== exp_word.done_op) begin
                        errors++;
                        $display("%0t: done_op expected %0d actual %0d", $time,
                                 exp_word.done_op, got.done_op);
                    end
                    if (got.tile_visible !== exp_word.tile_visible) begin
                        errors++;
                        $display("%0t: tile_visible expected %0d actual %0d", $time,
                                 exp_word.tile_visible, got.tile_visible);
                    end
                end
            end
        end
    end

    function automatic t_cmd make_cmd(logic [1:0] op, int ca, int ra, int cb, int rb,
                                      int rad, bit vis);
        t_cmd cmd;
        cmd.op = op;
        cmd.col_a = 6'(ca);
        cmd.row_a = 6'(ra);
        cmd.col_b = 6'(cb);
        cmd.row_b = 6'(rb);
        cmd.radius = 6'(rad);
        cmd.visible = vis;
        return cmd;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd cmd;
        logic [63:0] bits;
        int kind;
        bits = {$urandom, $urandom};
        cmd = bits[32:0];
        kind = int'($urandom_range(0, 19));
        if (kind < 7) cmd.op = tfg_pkg::OP_STAMP;
        else if (kind < 8) cmd.op = tfg_pkg::OP_FILL;
        else if (kind < 15) cmd.op = tfg_pkg::OP_QUERY;
        else cmd.op = tfg_pkg::OP_SOFTEN;
        // Soften mostly small rectangles; the rest keep their random second corner.
        if (cmd.op == tfg_pkg::OP_SOFTEN && $urandom_range(0, 9) != 0) begin
            cmd.col_b = 6'(clampi(int'(cmd.col_a) + int'($urandom_range(0, 6)), 0, 63));
            cmd.row_b = 6'(clampi(int'(cmd.row_a) + int'($urandom_range(0, 6)), 0, 63));
        end
        if (cmd.op == tfg_pkg::OP_STAMP && $urandom_range(0, 1))
            cmd.radius = 6'($urandom_range(0, 12));
        return cmd;
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || in_ch.valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [14:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tfg_pkg::CFG_FOG_ALPHA) fog_model = data[7:0];
        else ratio_model = data;
        @(posedge i_clk);
    endtask

    initial begin
        logic [14:0] ratios [6];
        logic [14:0] fogs [6];
        errors = 0;
        hold_sender = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = tfg_pkg::CFG_FOG_ALPHA;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = tfg_pkg::OP_QUERY;
        {in_ch.col_a, in_ch.row_a, in_ch.col_b, in_ch.row_b, in_ch.radius} = '0;
        in_ch.visible = 1'b0;
        out_ch.ready = 1'b0;
        fog_model = tfg_pkg::FOG_RESET;
        ratio_model = tfg_pkg::RATIO_RESET;
        for (int i = 0; i < CELLS; i++) grid_model[i] = tfg_pkg::FOG_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, out-of-border discs, radius zero, reversed rectangles.
        enqueue_cmd(make_cmd(tfg_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_STAMP, 32, 32, 0, 0, 10, 1));
        enqueue_cmd(make_cmd(tfg_pkg::OP_QUERY, 32, 32, 0, 0, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_STAMP, 0, 0, 63, 63, 63, 1));
        enqueue_cmd(make_cmd(tfg_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_QUERY, 1, 1, 0, 0, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_QUERY, 63, 63, 0, 0, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_STAMP, 63, 63, 0, 0, 20, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_STAMP, 5, 5, 0, 0, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_SOFTEN, 50, 50, 63, 63, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_SOFTEN, 0, 0, 63, 63, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_SOFTEN, 40, 40, 10, 10, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_QUERY, 62, 62, 0, 0, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_FILL, 0, 0, 0, 0, 0, 1));
        enqueue_cmd(make_cmd(tfg_pkg::OP_QUERY, 63, 0, 0, 0, 0, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_FILL, 63, 63, 63, 63, 63, 0));
        enqueue_cmd(make_cmd(tfg_pkg::OP_QUERY, 0, 63, 0, 0, 0, 0));
        wait_idle();

        ratios = '{15'd333, 15'd0, 15'h7FFF, 15'd25600, 15'd600, 15'd2000};
        fogs   = '{15'd1, 15'd0, 15'd255, 15'd128, 15'd77, 15'd200};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(tfg_pkg::CFG_FOG_ALPHA, fogs[ph]);
            write_reg(tfg_pkg::CFG_FADE_RATIO, ratios[ph]);
            for (int k = 0; k < 21; k++) enqueue_cmd(random_cmd());
            if (ph == 2) begin
                // Pause the sender until everything sent so far has come back.
                while (pending_cmds.size() > 10) @(posedge i_clk);
                hold_sender = 1'b1;
                while (in_ch.valid || expected_res.size() != 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_idle();
        end

        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
